// File: src/kaae_pkg.sv
// Package for the key admission and age eviction table.
// Holds the payload structs, operation and result codes, and sizes.
// No dependencies.
package kaae_pkg;

  localparam int unsigned NumEntries = 64;

  typedef enum logic [2:0] {
    OP_COUNT      = 3'd0,
    OP_FILTER     = 3'd1,
    OP_RECORD_TS  = 3'd2,
    OP_END_BATCH  = 3'd3,
    OP_LOAD_COUNT = 3'd4,
    OP_LOAD_TS    = 3'd5,
    OP_RSVD6      = 3'd6,
    OP_RSVD7      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_FILTER  = 2'd0,
    KIND_EVICTED = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  localparam logic [1:0] REG_ADMIT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ADMIT_ENABLE    = 2'd1;
  localparam logic [1:0] REG_AGE_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_EVICT_INTERVAL  = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [63:0] key;
    logic [31:0]        count;
    logic               count_given;
    logic [31:0]        timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] result_key;
    logic               last;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        lookup;     // not read by the cells; they always compare key, report hit and free
    logic        write;      // update the addressed cell
    logic        wr_count;   // write count field
    logic        wr_time;    // write time field
    logic        wr_key;     // write key (claim)
    logic        add;        // add to count (else load)
    logic [31:0] data;       // count or timestamp
    logic        sweep;      // sweep evaluation
    logic        clr_count;  // eviction also drops count
  } cell_ctl_t;

endpackage

// File: src/kaae_cell.sv
// One table entry: key, count and time with their valid bits.
// Depends on kaae_pkg. Hit and free marks go to the priority chain in the top level.
module kaae_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  kaae_pkg::cell_ctl_t    ctl,
  input  logic signed [63:0]     key_in,
  input  logic                   sel,          // this cell is addressed
  input  logic [31:0]            latest_time,
  input  logic [31:0]            age_threshold,
  input  logic                   evict_take,   // controller takes this eviction
  output logic                   hit,
  output logic                   free,
  output logic                   old,          // due for eviction
  output logic signed [63:0]     entry_key,
  output logic                   count_valid,
  output logic [31:0]            entry_count
);
  import kaae_pkg::*;

  logic        time_valid;
  logic [31:0] entry_time;
  logic [32:0] sum;
  logic signed [33:0] age;

  assign hit  = (count_valid | time_valid) && entry_key == key_in;
  assign free = !count_valid && !time_valid;
  assign age  = $signed({2'b00, latest_time}) - $signed({2'b00, entry_time});
  assign old  = time_valid && entry_key != -64'sd1 &&
                age > $signed({2'b00, age_threshold});
  assign sum  = (count_valid ? {1'b0, entry_count} : 33'd0) + {1'b0, ctl.data};

  // Hold or update the payload fields.
  always_ff @(posedge clk) begin
    if (ctl.write && sel) begin
      if (ctl.wr_key) entry_key <= key_in;
      if (ctl.wr_time) entry_time <= ctl.data;
      if (ctl.wr_count) begin
        if (ctl.add) entry_count <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        else entry_count <= ctl.data;
      end
    end
  end

  // Valid bits: clear on reset, set on write; eviction drops time, and count when clr_count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
      time_valid  <= 1'b0;
    end else if (ctl.write && sel) begin
      if (ctl.wr_count) count_valid <= 1'b1;
      if (ctl.wr_time) time_valid <= 1'b1;
    end else if (ctl.sweep && evict_take) begin
      time_valid <= 1'b0;
      if (ctl.clr_count) count_valid <= 1'b0;
    end
  end

  a_free_not_old: assert property (@(posedge clk) disable iff (rst) free |-> !old)
    else $error("free cell flagged old");
  a_evict_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep && evict_take && !(ctl.write && sel) |=> !time_valid)
    else $error("evicted cell kept time");
  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.write && sel && ctl.wr_count |=> count_valid)
    else $error("count write lost");
endmodule

// File: src/key_admission_and_age_eviction.sv
// Top level: controller, configuration registers and the chain of cells.
// Depends on kaae_pkg and kaae_cell.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_item (in_item_t)
//  out     | output    | out_valid/ out_ready | out_item (out_item_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// An item is registered in S_IDLE; S_EXEC matches the key across the cell chain,
// picks the first free cell and writes in the same cycle. No new item is taken
// until S_IDLE returns. A sweep walks the cells one per cycle up to the last cell
// due for eviction, with eviction results stalling on out_ready. An end of batch
// whose batch count ran past a lowered interval first reduces it in S_MOD.
// Reset is synchronous and clears all valid bits at once; no clearing pass.
module key_admission_and_age_eviction (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kaae_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kaae_pkg::out_item_t   out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import kaae_pkg::*;

  localparam int unsigned IdxW = $clog2(NumEntries);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_OUT   = 5'b01000,
    S_MOD   = 5'b10000
  } state_t;

  state_t     state;
  in_item_t   item;
  logic [31:0] admit_threshold, age_threshold, latest_time;
  logic        admit_enable, first_batch_seen;
  logic [15:0] evict_interval, batch_number;
  logic [IdxW-1:0] sweep_idx;
  logic        more_old;
  logic [16:0] mod_rem, mod_next;
  logic [4:0]  mod_step;
  logic [32:0] mod_sub;

  cell_ctl_t ctl;
  logic [NumEntries-1:0] hit, free, old, cval, sel, take;
  logic signed [63:0] ekey [NumEntries];
  logic [31:0] ecount [NumEntries];
  logic [NumEntries:0] hit_seen, free_seen;
  logic [NumEntries-1:0] hit_sel, free_sel;
  logic any_hit, any_free;
  logic [15:0] iv, nb;
  logic [16:0] nb_inc;
  logic hit_cval;
  logic [31:0] hit_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      admit_threshold <= '0;
      admit_enable    <= 1'b0;
      age_threshold   <= '0;
      evict_interval  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADMIT_THRESHOLD: admit_threshold <= cfg_data;
        REG_ADMIT_ENABLE:    admit_enable <= cfg_data[0];
        REG_AGE_THRESHOLD:   age_threshold <= cfg_data;
        REG_EVICT_INTERVAL:  evict_interval <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Priority chain: first hit and first free cell.
  always_comb begin
    hit_seen[0]  = 1'b0;
    free_seen[0] = 1'b0;
    for (int i = 0; i < NumEntries; i++) begin
      hit_sel[i]  = hit[i] && !hit_seen[i];
      free_sel[i] = free[i] && !free_seen[i];
      hit_seen[i+1]  = hit_seen[i] | hit[i];
      free_seen[i+1] = free_seen[i] | free[i];
    end
  end
  assign any_hit  = hit_seen[NumEntries];
  assign any_free = free_seen[NumEntries];
  assign sel = any_hit ? hit_sel : free_sel;

  always_comb begin
    hit_cval  = 1'b0;
    hit_count = '0;
    for (int i = 0; i < NumEntries; i++) begin
      if (hit_sel[i]) begin
        hit_cval  = cval[i];
        hit_count = ecount[i];
      end
    end
  end

  // Any cell past the sweep position still due for eviction.
  always_comb begin
    more_old = 1'b0;
    for (int i = 0; i < NumEntries; i++)
      if (i > int'(sweep_idx)) more_old = more_old | old[i];
  end

  // Broadcast control for the current operation.
  always_comb begin
    ctl = '0;
    ctl.clr_count = admit_enable;
    ctl.sweep = (state == S_SWEEP);
    if (state == S_EXEC) begin
      ctl.write  = (any_hit || any_free) &&
                   (item.operation == OP_COUNT || item.operation == OP_LOAD_COUNT ||
                    item.operation == OP_RECORD_TS || item.operation == OP_LOAD_TS);
      ctl.wr_key = !any_hit;
      ctl.wr_count = item.operation == OP_COUNT || item.operation == OP_LOAD_COUNT;
      ctl.wr_time  = item.operation == OP_RECORD_TS || item.operation == OP_LOAD_TS;
      ctl.add  = item.operation == OP_COUNT;
      ctl.data = ctl.wr_time ? item.timestamp :
                 (item.operation == OP_COUNT && !item.count_given) ? 32'd1 : item.count;
    end
  end

  always_comb begin
    take = '0;
    take[sweep_idx] = (state == S_SWEEP) && old[sweep_idx] && (!out_valid || out_ready);
  end

  for (genvar g = 0; g < NumEntries; g++) begin : g_cell
    kaae_cell u_cell (
      .clk, .rst, .ctl,
      .key_in        (item.key),
      .sel           (sel[g]),
      .latest_time   (latest_time),
      .age_threshold (age_threshold),
      .evict_take    (take[g]),
      .hit           (hit[g]),
      .free          (free[g]),
      .old           (old[g]),
      .entry_key     (ekey[g]),
      .count_valid   (cval[g]),
      .entry_count   (ecount[g])
    );
  end

  assign iv     = (evict_interval == 16'd0) ? 16'd1 : evict_interval;
  assign nb_inc = {1'b0, batch_number} + 17'd1;
  assign nb     = (nb_inc >= {1'b0, iv}) ? 16'd0 : nb_inc[15:0];
  assign in_ready = (state == S_IDLE);

  // Remainder step: subtract the interval shifted by mod_step when it fits.
  assign mod_sub  = {17'd0, iv} << mod_step;
  assign mod_next = ({16'd0, mod_rem} >= mod_sub) ? mod_rem - mod_sub[16:0] : mod_rem;

  // Sequencer: accept, execute, reduce, sweep, drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      latest_time <= '0;
      batch_number <= '0;
      first_batch_seen <= 1'b0;
      sweep_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          unique case (op_t'(item.operation))
            OP_COUNT, OP_LOAD_COUNT, OP_RECORD_TS, OP_LOAD_TS: begin
              if (!any_hit && !any_free) begin
                out_item  <= '{KIND_FULL, item.key, 1'b1};
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else if (item.operation == OP_RECORD_TS && item.timestamp > latest_time) begin
                latest_time <= item.timestamp;
              end
            end
            OP_FILTER: begin
              out_item.kind <= KIND_FILTER;
              out_item.last <= 1'b1;
              out_item.result_key <= (admit_enable && any_hit && hit_cval &&
                                      hit_count < admit_threshold) ? -64'sd1 : item.key;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
            OP_END_BATCH: begin
              if (nb_inc > {1'b0, iv}) begin
                // Batch count ran past the interval: reduce it first.
                mod_rem  <= nb_inc;
                mod_step <= 5'd16;
                state    <= S_MOD;
              end else begin
                batch_number <= nb;
                first_batch_seen <= 1'b1;
                if (first_batch_seen && nb == 16'd0 && age_threshold != 32'd0) begin
                  sweep_idx <= '0;
                  state     <= S_SWEEP;
                end
              end
            end
            default: ;
          endcase
        end
        S_MOD: begin
          mod_rem  <= mod_next;
          mod_step <= mod_step - 5'd1;
          if (mod_step == 5'd0) begin
            batch_number <= mod_next[15:0];
            first_batch_seen <= 1'b1;
            if (first_batch_seen && mod_next == 17'd0 && age_threshold != 32'd0) begin
              sweep_idx <= '0;
              state     <= S_SWEEP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SWEEP: begin
          // Advance when the output slot is free; mark the final eviction as last.
          if (!out_valid || out_ready) begin
            out_valid <= old[sweep_idx];
            if (old[sweep_idx]) begin
              out_item <= '{KIND_EVICTED, ekey[sweep_idx], !more_old};
            end
            if (!more_old) begin
              state <= old[sweep_idx] ? S_OUT : S_IDLE;
            end else begin
              sweep_idx <= sweep_idx + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted item not executed");
  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_sel))
    else $error("multiple hits selected");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> out_valid)
    else $error("drain state without result");
endmodule

// File: test/key_admission_and_age_eviction_tb.sv
// Testbench for the key admission and age eviction table.
// Drives random and directed transactions, predicts results with its own table model.
// Depends on kaae_pkg and key_admission_and_age_eviction.
`timescale 1ns / 1ps

module key_admission_and_age_eviction_tb;
  import kaae_pkg::*;

  localparam int SlotCount = 64;
  localparam int IdleLimit = 20000;

  // Table model and queue of expected results
  class table_scoreboard;
    logic [63:0] slot_key [SlotCount];
    logic [31:0] slot_count [SlotCount];
    logic [31:0] slot_time [SlotCount];
    bit count_ok [SlotCount];
    bit time_ok [SlotCount];
    logic [31:0] newest_time;
    logic [15:0] batch_idx;
    bit seen_batch;
    logic [31:0] threshold;
    bit admit_on;
    logic [31:0] max_age;
    logic [15:0] interval;
    out_item_t pending [$];
    int errors;

    function void clear();
      for (int i = 0; i < SlotCount; i++) begin
        count_ok[i] = 0;
        time_ok[i] = 0;
        slot_key[i] = '0;
      end
      newest_time = 0;
      batch_idx = 0;
      seen_batch = 0;
      threshold = 0;
      admit_on = 0;
      max_age = 0;
      interval = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ADMIT_THRESHOLD: threshold = val;
        REG_ADMIT_ENABLE: admit_on = val[0];
        REG_AGE_THRESHOLD: max_age = val;
        REG_EVICT_INTERVAL: interval = val[15:0];
        default: ;
      endcase
    endfunction

    function int find_slot(logic [63:0] k);
      for (int i = 0; i < SlotCount; i++)
        if ((count_ok[i] || time_ok[i]) && slot_key[i] == k) return i;
      return -1;
    endfunction

    function int claim_slot(logic [63:0] k);
      int s;
      s = find_slot(k);
      if (s >= 0) return s;
      for (int i = 0; i < SlotCount; i++)
        if (!count_ok[i] && !time_ok[i]) begin
          slot_key[i] = k;
          return i;
        end
      return -1;
    endfunction

    function void push(kind_t kd, logic [63:0] k);
      out_item_t r;
      r.kind = kd;
      r.result_key = k;
      r.last = 0;
      pending.push_back(r);
    endfunction

    // Note an accepted input and queue the results it causes
    function void note_input(in_item_t it);
      int s;
      int n;
      int base;
      logic [32:0] sum;
      logic [15:0] iv;
      logic [15:0] nb;
      longint age;
      n = 0;
      base = pending.size();
      case (op_t'(it.operation))
        OP_COUNT, OP_LOAD_COUNT: begin
          s = claim_slot(it.key);
          if (s < 0) begin
            push(KIND_FULL, it.key);
            n = 1;
          end else begin
            if (it.operation == OP_LOAD_COUNT) slot_count[s] = it.count;
            else begin
              sum = (count_ok[s] ? {1'b0, slot_count[s]} : 33'd0) +
                    (it.count_given ? {1'b0, it.count} : 33'd1);
              slot_count[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            count_ok[s] = 1;
          end
        end
        OP_FILTER: begin
          s = find_slot(it.key);
          if (admit_on && s >= 0 && count_ok[s] && slot_count[s] < threshold)
            push(KIND_FILTER, '1);
          else
            push(KIND_FILTER, it.key);
          n = 1;
        end
        OP_RECORD_TS, OP_LOAD_TS: begin
          s = claim_slot(it.key);
          if (s < 0) begin
            push(KIND_FULL, it.key);
            n = 1;
          end else begin
            slot_time[s] = it.timestamp;
            time_ok[s] = 1;
            if (it.operation == OP_RECORD_TS && it.timestamp > newest_time)
              newest_time = it.timestamp;
          end
        end
        OP_END_BATCH: begin
          iv = (interval == 0) ? 16'd1 : interval;
          nb = 16'((32'(batch_idx) + 1) % iv);
          if (seen_batch && nb == 0 && max_age != 0) begin
            for (int i = 0; i < SlotCount && n < SlotCount; i++) begin
              if (!time_ok[i] || slot_key[i] == '1) continue;
              age = longint'(newest_time) - longint'(slot_time[i]);
              if (age > longint'(max_age)) begin
                push(KIND_EVICTED, slot_key[i]);
                n++;
                time_ok[i] = 0;
                if (admit_on) count_ok[i] = 0;
              end
            end
          end
          batch_idx = nb;
          seen_batch = 1;
        end
        default: ;
      endcase
      if (n > 0) pending[base + n - 1].last = 1;
    endfunction

    // Compare a result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d key=%0h last=%0d", $time,
                  got.kind, got.result_key, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.result_key !== want.result_key) begin
        $display("%0t: result_key expected %0h actual %0h", $time,
                 want.result_key, got.result_key);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  table_scoreboard sb;
  bit calm = 0;
  bit sink_on = 0;
  int idle_cycles = 0;
  logic [63:0] key_pool [16];

  always #5 clk = ~clk;

  key_admission_and_age_eviction dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL key_admission_and_age_eviction");
        $finish;
      end
    end
  end

  // Receiver with random stall bursts
  initial begin
    int burst;
    wait (sink_on);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        burst = $urandom_range(1, 8);
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1;
      burst = $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  // Send one transaction, with an optional gap first; valid stays up until
  // the next transaction or an idle stretch replaces it
  task automatic send(logic [2:0] op, logic [63:0] k, logic [31:0] c, bit g,
                      logic [31:0] ts);
    in_item_t it;
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    it.operation = op;
    it.key = k;
    it.count = c;
    it.count_given = g;
    it.timestamp = ts;
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Drop valid, wait until the block has drained, then let it settle
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [2:0] op;
    logic [63:0] k;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) op = OP_COUNT;
      else if (pick < 42) op = OP_FILTER;
      else if (pick < 62) op = OP_RECORD_TS;
      else if (pick < 74) op = OP_END_BATCH;
      else if (pick < 84) op = OP_LOAD_COUNT;
      else if (pick < 94) op = OP_LOAD_TS;
      else op = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 15)];
      else k = {$urandom, $urandom};
      send(op, k, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20),
           1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0) ? $urandom :
           $urandom_range(0, 400));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '1;
    key_pool[1] = 64'h8000_0000_0000_0000;
    key_pool[2] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[3] = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    sink_on = 1;

    // Directed: admission, saturation, filter cases
    write_reg(REG_ADMIT_THRESHOLD, 32'd5);
    write_reg(REG_ADMIT_ENABLE, 32'd1);
    write_reg(REG_AGE_THRESHOLD, 32'd10);
    write_reg(REG_EVICT_INTERVAL, 32'd0);
    send(OP_FILTER, 64'd77, 0, 0, 0);
    send(OP_COUNT, 64'd77, 0, 0, 0);
    send(OP_FILTER, 64'd77, 0, 0, 0);
    send(OP_COUNT, 64'd77, 32'hFFFF_FFFF, 1, 0);
    send(OP_COUNT, 64'd77, 32'd9, 1, 0);
    send(OP_FILTER, 64'd77, 0, 0, 0);
    send(OP_LOAD_COUNT, '1, 32'd1, 0, 32'hFFFF_FFFF);
    send(OP_FILTER, '1, 0, 0, 0);
    send(OP_LOAD_TS, 64'h8000_0000_0000_0000, 0, 0, 32'd0);
    send(OP_RECORD_TS, '1, 0, 0, 32'd0);
    send(OP_RECORD_TS, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 32'd100);
    send(OP_LOAD_TS, 64'd5, 0, 0, 32'hFFFF_FFFF);
    send(OP_END_BATCH, 0, 0, 0, 0);
    send(OP_END_BATCH, 0, 0, 0, 0);
    send(3'(OP_RSVD6), 64'd1, 0, 0, 0);
    send(3'(OP_RSVD7), 64'd1, 0, 0, 0);
    send(OP_FILTER, 64'h8000_0000_0000_0000, 0, 0, 0);
    drain();

    // Fill the table to provoke the full error
    for (int i = 0; i < SlotCount + 2; i++)
      send(OP_LOAD_TS, 64'h1000 + i, 0, 0, 32'd1);
    send(OP_COUNT, 64'hABCD, 0, 0, 0);
    send(OP_RECORD_TS, 64'h1000_0000, 0, 0, 32'd500);
    send(OP_END_BATCH, 0, 0, 0, 0);
    drain();

    // Random phases over several settings, extremes included
    write_reg(REG_ADMIT_ENABLE, 32'd0);
    write_reg(REG_AGE_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_EVICT_INTERVAL, 32'hFFFF);
    random_phase(30);
    drain();
    write_reg(REG_ADMIT_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_ADMIT_ENABLE, 32'd1);
    write_reg(REG_AGE_THRESHOLD, 32'd1);
    write_reg(REG_EVICT_INTERVAL, 32'd1);
    random_phase(50);
    drain();
    write_reg(REG_ADMIT_THRESHOLD, 32'd0);
    write_reg(REG_AGE_THRESHOLD, 32'd0);
    write_reg(REG_EVICT_INTERVAL, 32'd2);
    random_phase(30);
    drain();
    write_reg(REG_ADMIT_THRESHOLD, 32'd8);
    write_reg(REG_AGE_THRESHOLD, 32'd50);
    write_reg(REG_EVICT_INTERVAL, 32'd3);
    random_phase(40);
    // Calm tail with no idling
    calm = 1;
    random_phase(34);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("PASS key_admission_and_age_eviction");
    else $display("FAIL key_admission_and_age_eviction");
    $finish;
  end

endmodule

// File: filelist.f
src/kaae_pkg.sv
src/kaae_cell.sv
src/key_admission_and_age_eviction.sv
test/key_admission_and_age_eviction_tb.sv
